// File: rtl/room_allocation_scheduler_core_defines.svh
// Assertion helpers shared by the scheduler RTL.
`ifndef ROOM_ALLOCATION_SCHEDULER_CORE_DEFINES_SVH
`define ROOM_ALLOCATION_SCHEDULER_CORE_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define RAS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define RAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/ras_pkg.sv
`timescale 1ns / 1ps

package ras_pkg;

   localparam int ROOM_COUNT_DEF = 16;
   localparam int IN_TIME_W      = 32;
   localparam int TIME_W         = 48;
   localparam int COUNT_W        = 16;
   localparam int ROOM_OUT_W     = 4;
   localparam int CSR_W          = 5;

   localparam logic [CSR_W-1:0]   CSR_ROOMS_RESET = 5'd16;
   localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_PICK,
      ST_UPD
   } state_type;

   // room table port control
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear_all;
   } tbl_cmd_type;

   // compare unit control
   typedef struct packed {
      logic init;
      logic cmp_en;
   } scan_cmd_type;

endpackage

// File: rtl/ras_channels.sv
`timescale 1ns / 1ps

interface ras_req_if;
   import ras_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [IN_TIME_W-1:0] start_time;
   logic [IN_TIME_W-1:0] end_time;
   logic                 first_of_set;

   modport source (output valid, output start_time, output end_time, output first_of_set,
                   input ready);
   modport sink   (input valid, input start_time, input end_time, input first_of_set,
                   output ready);
endinterface

interface ras_rsp_if;
   import ras_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [ROOM_OUT_W-1:0] assigned_room;
   logic [TIME_W-1:0]     finish_time;
   logic [ROOM_OUT_W-1:0] busiest_room;
   logic [COUNT_W-1:0]    busiest_count;

   modport source (output valid, output assigned_room, output finish_time,
                   output busiest_room, output busiest_count, input ready);
   modport sink   (input valid, input assigned_room, input finish_time,
                   input busiest_room, input busiest_count, output ready);
endinterface

// File: rtl/ras_room_table.sv
`timescale 1ns / 1ps

module ras_room_table #(
   parameter int ROOM_COUNT = 16,
   parameter int IDX_W      = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ras_pkg::tbl_cmd_type        cmd,
   input  logic [IDX_W-1:0]            rd_addr,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic [ras_pkg::TIME_W-1:0]  wr_free,
   input  logic [ras_pkg::COUNT_W-1:0] wr_count,
   output logic [ras_pkg::TIME_W-1:0]  rd_free,
   output logic [ras_pkg::COUNT_W-1:0] rd_count
);
   import ras_pkg::*;

   logic [TIME_W-1:0]  free_mem [ROOM_COUNT];
   logic [COUNT_W-1:0] cnt_mem  [ROOM_COUNT];

   logic [ROOM_COUNT-1:0] valid_ff, valid_in;
   logic [TIME_W-1:0]     rd_free_ff;
   logic [COUNT_W-1:0]    rd_cnt_ff;
   logic                  rd_vld_ff;

   // an entry not written since the last clear reads as zero
   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear_all) begin
         valid_in = '0;
      end else if (cmd.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         free_mem[wr_addr] <= wr_free;
         cnt_mem[wr_addr]  <= wr_count;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_free_ff <= free_mem[rd_addr];
         rd_cnt_ff  <= cnt_mem[rd_addr];
         rd_vld_ff  <= valid_ff[rd_addr];
      end
   end

   assign rd_free  = rd_vld_ff ? rd_free_ff : '0;
   assign rd_count = rd_vld_ff ? rd_cnt_ff  : '0;

endmodule

// File: rtl/ras_scan_unit.sv
`timescale 1ns / 1ps

module ras_scan_unit #(
   parameter int IDX_W = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ras_pkg::scan_cmd_type         cmd,
   input  logic [ras_pkg::IN_TIME_W-1:0] start_time,
   input  logic [ras_pkg::TIME_W-1:0]    cand_free,
   input  logic [IDX_W-1:0]              cand_idx,
   output logic                          found,
   output logic [IDX_W-1:0]              first_idx,
   output logic [IDX_W-1:0]              min_idx,
   output logic [ras_pkg::TIME_W-1:0]    min_free
);
   import ras_pkg::*;

   logic              found_ff, found_in;
   logic [IDX_W-1:0]  first_ff, first_in;
   logic [IDX_W-1:0]  min_idx_ff, min_idx_in;
   logic [TIME_W-1:0] min_free_ff, min_free_in;

   // one room per cycle: first free room and earliest-freeing room (strict <)
   always_comb begin
      found_in    = found_ff;
      first_in    = first_ff;
      min_idx_in  = min_idx_ff;
      min_free_in = min_free_ff;
      if (cmd.init) begin
         found_in = 1'b0;
      end else if (cmd.cmp_en) begin
         if (!found_ff && (cand_free <= TIME_W'(start_time))) begin
            found_in = 1'b1;
            first_in = cand_idx;
         end
         if ((cand_idx == '0) || (cand_free < min_free_ff)) begin
            min_idx_in  = cand_idx;
            min_free_in = cand_free;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff    <= first_in;
      min_idx_ff  <= min_idx_in;
      min_free_ff <= min_free_in;
   end

   assign found     = found_ff;
   assign first_idx = first_ff;
   assign min_idx   = min_idx_ff;
   assign min_free  = min_free_ff;

endmodule

// File: rtl/room_allocation_scheduler_core.sv
`timescale 1ns / 1ps
// An accepted request beat runs through scan, drain, pick and update, scanning n rooms, where n is
// rooms_in_use clamped to 1 .. ROOM_COUNT; update waits until the response register is free.
// Requests are taken only in idle, one at a time; the room table is scanned one room per cycle
// through a single registered read port and one shared compare unit.
// Reset (synchronous, active high) clears all room state and the busiest tracker and sets
// rooms_in_use to 16; no clearing pass is needed.

module room_allocation_scheduler_core #(
   parameter int ROOM_COUNT = ras_pkg::ROOM_COUNT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   ras_req_if.sink                   req_chan,
   ras_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [ras_pkg::CSR_W-1:0] csr_wr_data
);
   import ras_pkg::*;

   localparam int IDX_W = (ROOM_COUNT > 1) ? $clog2(ROOM_COUNT) : 1;
   localparam int CNT_W = $clog2(ROOM_COUNT + 1);

   state_type state_ff, state_in;

   logic [CSR_W-1:0]      csr_rooms_ff;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [IN_TIME_W-1:0]  start_ff, start_in;
   logic [IN_TIME_W-1:0]  dur_ff, dur_in;
   logic [CNT_W-1:0]      issue_ff, issue_in;
   logic                  cmp_en_ff;
   logic [IDX_W-1:0]      cmp_idx_ff;
   logic [IDX_W-1:0]      room_ff, room_in;
   logic [TIME_W-1:0]     finish_ff, finish_in;
   logic [IDX_W-1:0]      best_room_ff, best_room_in;
   logic [COUNT_W-1:0]    best_count_ff, best_count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ROOM_OUT_W-1:0] rsp_room_ff;
   logic [TIME_W-1:0]     rsp_finish_ff;
   logic [ROOM_OUT_W-1:0] rsp_best_room_ff;
   logic [COUNT_W-1:0]    rsp_best_count_ff;

   logic                  accept;
   logic                  last_issue;
   logic                  upd_go;
   logic                  rsp_load;
   logic [31:0]           n_wide;
   tbl_cmd_type           tbl_cmd;
   scan_cmd_type          scan_cmd;
   logic [IDX_W-1:0]      rd_addr;
   logic [TIME_W-1:0]     rd_free;
   logic [COUNT_W-1:0]    rd_count;
   logic                  found;
   logic [IDX_W-1:0]      first_idx;
   logic [IDX_W-1:0]      min_idx;
   logic [TIME_W-1:0]     min_free;
   logic [IDX_W-1:0]      room_sel;
   logic [TIME_W-1:0]     base;
   logic [TIME_W:0]       finish_sum;
   logic [COUNT_W-1:0]    cnt_new;

   assign accept     = req_chan.valid && req_chan.ready;
   assign last_issue = (issue_ff == (n_ff - CNT_W'(1)));
   assign upd_go     = !rsp_valid_ff || rsp_chan.ready;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept)     state_in = ST_SCAN;
         ST_SCAN:  if (last_issue) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_PICK;
         ST_PICK:  state_in = ST_UPD;
         ST_UPD:   if (upd_go)     state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---------------- outputs of the sequencer ----------------
   // ready is high throughout idle, so valid alone marks the accepting beat here
   always_comb begin
      tbl_cmd         = '0;
      scan_cmd        = '0;
      rsp_load        = 1'b0;
      req_chan.ready  = 1'b0;
      scan_cmd.cmp_en = cmp_en_ff;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready    = 1'b1;
            scan_cmd.init     = req_chan.valid;
            tbl_cmd.clear_all = req_chan.valid && req_chan.first_of_set;
         end
         ST_SCAN:  tbl_cmd.rd_en = 1'b1;
         ST_DRAIN: ;
         ST_PICK:  tbl_cmd.rd_en = 1'b1;
         ST_UPD: begin
            tbl_cmd.wr_en = upd_go;
            rsp_load      = upd_go;
         end
         default: ;
      endcase
   end

   // clamp the room count to 1 .. ROOM_COUNT
   always_comb begin
      if (csr_rooms_ff == '0) begin
         n_wide = 32'd1;
      end else if (32'(csr_rooms_ff) > ROOM_COUNT) begin
         n_wide = 32'(ROOM_COUNT);
      end else begin
         n_wide = 32'(csr_rooms_ff);
      end
   end

   assign room_sel   = found ? first_idx : min_idx;
   assign base       = found ? TIME_W'(start_ff) : min_free;
   assign finish_sum = {1'b0, base} + (TIME_W + 1)'(dur_ff);
   assign rd_addr    = (state_ff == ST_PICK) ? room_sel : issue_ff[IDX_W-1:0];
   assign cnt_new    = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_W'(1);

   always_comb begin
      n_in          = n_ff;
      start_in      = start_ff;
      dur_in        = dur_ff;
      issue_in      = issue_ff;
      room_in       = room_ff;
      finish_in     = finish_ff;
      best_room_in  = best_room_ff;
      best_count_in = best_count_ff;
      if (accept) begin
         n_in     = n_wide[CNT_W-1:0];
         start_in = req_chan.start_time;
         dur_in   = (req_chan.end_time > req_chan.start_time) ?
                    req_chan.end_time - req_chan.start_time : '0;
         issue_in = '0;
         if (req_chan.first_of_set) begin
            best_room_in  = '0;
            best_count_in = '0;
         end
      end
      if (state_ff == ST_SCAN) begin
         issue_in = issue_ff + CNT_W'(1);
      end
      if (state_ff == ST_PICK) begin
         room_in   = room_sel;
         finish_in = finish_sum[TIME_W] ? '1 : finish_sum[TIME_W-1:0];
      end
      if (rsp_load) begin
         if ((cnt_new > best_count_ff) ||
             ((cnt_new == best_count_ff) && (room_ff < best_room_ff))) begin
            best_room_in  = room_ff;
            best_count_in = cnt_new;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         csr_rooms_ff  <= CSR_ROOMS_RESET;
         cmp_en_ff     <= 1'b0;
         best_room_ff  <= '0;
         best_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cmp_en_ff     <= (state_ff == ST_SCAN);
         best_room_ff  <= best_room_in;
         best_count_ff <= best_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            csr_rooms_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      start_ff   <= start_in;
      dur_ff     <= dur_in;
      issue_ff   <= issue_in;
      cmp_idx_ff <= issue_ff[IDX_W-1:0];
      room_ff    <= room_in;
      finish_ff  <= finish_in;
      if (rsp_load) begin
         rsp_room_ff       <= ROOM_OUT_W'(room_ff);
         rsp_finish_ff     <= finish_ff;
         rsp_best_room_ff  <= ROOM_OUT_W'(best_room_in);
         rsp_best_count_ff <= best_count_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.assigned_room = rsp_room_ff;
   assign rsp_chan.finish_time   = rsp_finish_ff;
   assign rsp_chan.busiest_room  = rsp_best_room_ff;
   assign rsp_chan.busiest_count = rsp_best_count_ff;

   ras_room_table #(
      .ROOM_COUNT (ROOM_COUNT),
      .IDX_W      (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (tbl_cmd),
      .rd_addr  (rd_addr),
      .wr_addr  (room_ff),
      .wr_free  (finish_ff),
      .wr_count (cnt_new),
      .rd_free  (rd_free),
      .rd_count (rd_count)
   );

   ras_scan_unit #(
      .IDX_W (IDX_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .cmd        (scan_cmd),
      .start_time (start_ff),
      .cand_free  (rd_free),
      .cand_idx   (cmp_idx_ff),
      .found      (found),
      .first_idx  (first_idx),
      .min_idx    (min_idx),
      .min_free   (min_free)
   );

`include "room_allocation_scheduler_core_defines.svh"

   `RAS_ASSERT_NEXT(a_accept_starts_scan, clock, reset, accept, state_ff == ST_SCAN, "accepted beat did not start a scan")
   `RAS_ASSERT_NEXT(a_first_clears_best, clock, reset, accept && req_chan.first_of_set, best_count_ff == '0, "first of set did not clear busiest tracker")
   `RAS_ASSERT(a_room_in_range, clock, reset, (state_ff != ST_UPD) || (CNT_W'(room_ff) < n_ff), "assigned room beyond active count")
   `RAS_ASSERT(a_finish_not_early, clock, reset, (state_ff != ST_PICK) || (finish_in >= TIME_W'(start_ff)), "finish time before requested start")
   `RAS_ASSERT_NEXT(a_best_dominates, clock, reset, rsp_load, best_count_ff >= $past(cnt_new), "busiest count below a room count just written")

endmodule

// File: tb/ras_booking_checker.sv
`timescale 1ns / 1ps

module ras_booking_checker
   import ras_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   ras_req_if               req_mon,
   ras_rsp_if               rsp_mon,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data,
   output int               mismatches,
   output int               outstanding
);

   typedef struct packed {
      logic [ROOM_OUT_W-1:0] room;
      logic [TIME_W-1:0]     finish;
      logic [ROOM_OUT_W-1:0] busiest;
      logic [COUNT_W-1:0]    busiest_uses;
   } booking_type;

   localparam logic [TIME_W-1:0] TIME_CEILING = '1;

   logic [TIME_W-1:0]  free_at   [ROOM_COUNT_DEF];
   logic [COUNT_W-1:0] use_count [ROOM_COUNT_DEF];
   int                 busiest_idx;
   logic [COUNT_W-1:0] busiest_uses;
   logic [CSR_W-1:0]   rooms_setting;
   booking_type        expected_bookings [$];

   function automatic void wipe_rooms();
      for (int i = 0; i < ROOM_COUNT_DEF; i++) begin
         free_at[i]   = '0;
         use_count[i] = '0;
      end
      busiest_idx  = 0;
      busiest_uses = '0;
   endfunction

   function automatic booking_type book_room(input logic [IN_TIME_W-1:0] start_t,
                                             input logic [IN_TIME_W-1:0] end_t,
                                             input logic                 clear_first);
      booking_type         r;
      int                  n;
      int                  pick;
      bit                  found;
      logic [IN_TIME_W-1:0] dur;
      logic [TIME_W-1:0]   base;
      logic [TIME_W:0]     finish;
      if (clear_first)
         wipe_rooms();
      if (rooms_setting == 0)
         n = 1;
      else if (rooms_setting > ROOM_COUNT_DEF)
         n = ROOM_COUNT_DEF;
      else
         n = int'(rooms_setting);
      dur   = (end_t > start_t) ? end_t - start_t : '0;
      pick  = 0;
      found = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (!found && free_at[i] <= TIME_W'(start_t)) begin
            pick  = i;
            found = 1'b1;
         end
      end
      if (found) begin
         base = TIME_W'(start_t);
      end else begin
         // every room busy: earliest to free, lowest index on ties
         for (int i = 1; i < n; i++)
            if (free_at[i] < free_at[pick])
               pick = i;
         base = free_at[pick];
      end
      finish = {1'b0, base} + (TIME_W + 1)'(dur);
      if (finish > {1'b0, TIME_CEILING})
         finish = {1'b0, TIME_CEILING};
      free_at[pick] = finish[TIME_W-1:0];
      if (use_count[pick] != COUNT_MAX)
         use_count[pick] = use_count[pick] + COUNT_W'(1);
      if (use_count[pick] > busiest_uses ||
          (use_count[pick] == busiest_uses && pick < busiest_idx)) begin
         busiest_uses = use_count[pick];
         busiest_idx  = pick;
      end
      r.room         = pick[ROOM_OUT_W-1:0];
      r.finish       = finish[TIME_W-1:0];
      r.busiest      = busiest_idx[ROOM_OUT_W-1:0];
      r.busiest_uses = busiest_uses;
      return r;
   endfunction

   always @(posedge clock) begin
      booking_type want;
      if (reset) begin
         rooms_setting = CSR_ROOMS_RESET;
         wipe_rooms();
         expected_bookings.delete();
         mismatches = 0;
      end else begin
         if (csr_wr_en)
            rooms_setting = csr_wr_data;
         if (req_mon.valid && req_mon.ready)
            expected_bookings.push_back(book_room(req_mon.start_time, req_mon.end_time,
                                                  req_mon.first_of_set));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_bookings.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected response beat: room %0d finish %0h busiest %0d/%0d",
                           $time, rsp_mon.assigned_room, rsp_mon.finish_time,
                           rsp_mon.busiest_room, rsp_mon.busiest_count);
            end else begin
               want = expected_bookings.pop_front();
               if (rsp_mon.assigned_room !== want.room ||
                   rsp_mon.finish_time   !== want.finish ||
                   rsp_mon.busiest_room  !== want.busiest ||
                   rsp_mon.busiest_count !== want.busiest_uses) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: booking mismatch (exp/act): room %0d/%0d finish %0h/%0h",
                               " busiest %0d/%0d count %0d/%0d"},
                              $time, want.room, rsp_mon.assigned_room,
                              want.finish, rsp_mon.finish_time,
                              want.busiest, rsp_mon.busiest_room,
                              want.busiest_uses, rsp_mon.busiest_count);
               end
            end
         end
      end
      outstanding = expected_bookings.size();
   end

endmodule

// File: tb/room_allocation_scheduler_core_tb.sv
`timescale 1ns / 1ps

module room_allocation_scheduler_core_tb;
   import ras_pkg::*;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;
   bit               steady_flow = 1'b0;
   int               resp_hold;
   int               mismatches;
   int               outstanding;

   ras_req_if req_chan ();
   ras_rsp_if rsp_chan ();

   room_allocation_scheduler_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ras_booking_checker booking_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: each beat draws how long the next one is held off while valid
   always @(posedge clock) begin
      if (reset) begin
         resp_hold = 0;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            resp_hold = steady_flow ? 0 : $urandom_range(0, 7);
         else if (rsp_chan.valid && resp_hold > 0)
            resp_hold--;
         rsp_chan.ready <= (resp_hold == 0);
      end
   end

   task automatic push_booking(input logic [IN_TIME_W-1:0] start_t,
                               input logic [IN_TIME_W-1:0] end_t,
                               input logic                 clear_first);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.start_time   <= start_t;
      req_chan.end_time     <= end_t;
      req_chan.first_of_set <= clear_first;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // hold the sender until every booking has been answered and the core is idle
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_rooms(input logic [CSR_W-1:0] value, input bit flow);
      settle();
      steady_flow = flow;
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // mostly ordered sets with random content, plus some malformed beats
   task automatic random_traffic(input int budget);
      logic [IN_TIME_W:0]   cursor;
      logic [IN_TIME_W-1:0] start_t;
      logic [IN_TIME_W-1:0] end_t;
      logic [IN_TIME_W-1:0] dur;
      logic                 clear_first;
      int                   set_len;
      int                   quirk;
      int                   sent;
      sent = 0;
      while (sent < budget) begin
         set_len = $urandom_range(1, 40);
         if ($urandom_range(0, 3) == 0)
            cursor = {1'b0, $urandom()};
         else
            cursor = (IN_TIME_W + 1)'($urandom_range(0, 500));
         for (int k = 0; k < set_len && sent < budget; k++) begin
            cursor = cursor + (IN_TIME_W + 1)'($urandom_range(0, 8));
            if (cursor[IN_TIME_W])
               cursor = {1'b0, {IN_TIME_W{1'b1}}};
            start_t     = cursor[IN_TIME_W-1:0];
            dur         = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(1, 120);
            clear_first = (k == 0) && ($urandom_range(0, 4) != 0);
            quirk       = $urandom_range(0, 15);
            case (quirk)
               0: start_t = $urandom();
               1: dur = '0;
               2: clear_first = 1'($urandom_range(0, 1));
               default: ;
            endcase
            if ((IN_TIME_W + 1)'(start_t) + (IN_TIME_W + 1)'(dur) > {1'b0, {IN_TIME_W{1'b1}}})
               end_t = '1;
            else
               end_t = start_t + dur;
            if (quirk == 3)
               end_t = $urandom_range(0, start_t);
            push_booking(start_t, end_t, clear_first);
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      int drain_cycles;
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      req_chan.valid        = 1'b0;
      req_chan.start_time   = '0;
      req_chan.end_time     = '0;
      req_chan.first_of_set = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, zero and negative spans, out of order, tables full
      push_booking(32'd0, 32'd1, 1'b1);
      push_booking(32'd0, 32'hFFFF_FFFF, 1'b0);
      push_booking(32'd5, 32'd5, 1'b0);
      push_booking(32'd5, 32'd3, 1'b0);
      push_booking(32'd2, 32'd10, 1'b0);
      push_booking(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      // shrink mid-set: higher rooms keep their counts
      program_rooms(5'd2, 1'b0);
      push_booking(32'd100, 32'd200, 1'b0);
      push_booking(32'd100, 32'd200, 1'b0);
      program_rooms(5'd0, 1'b0);
      push_booking(32'd7, 32'd8, 1'b1);
      push_booking(32'd7, 32'd9, 1'b0);
      program_rooms(5'd31, 1'b0);
      push_booking(32'd10, 32'd1000, 1'b1);
      repeat (15) push_booking(32'd10, 32'd1000, 1'b0);
      push_booking(32'd11, 32'd20, 1'b0);
      push_booking(32'd1000, 32'd1001, 1'b0);

      program_rooms(5'd16, 1'b0);
      random_traffic(200);
      program_rooms(5'd3, 1'b1);
      random_traffic(150);
      program_rooms(5'd1, 1'b0);
      random_traffic(100);
      program_rooms(5'd0, 1'b0);
      random_traffic(60);
      program_rooms(5'd31, 1'b0);
      random_traffic(100);
      settle();
      random_traffic(100);
      program_rooms(5'd17, 1'b1);
      random_traffic(80);
      program_rooms(5'd2, 1'b0);
      random_traffic(100);
      repeat (3) begin
         program_rooms(CSR_W'($urandom_range(1, 16)), bit'($urandom_range(0, 1)));
         random_traffic(100);
      end

      // one room, longest spans back to back: delays pile up past 32 bits
      program_rooms(5'd1, 1'b1);
      push_booking(32'd0, 32'hFFFF_FFFF, 1'b1);
      repeat (30) push_booking(32'd0, 32'hFFFF_FFFF, 1'b0);
      program_rooms(5'd16, 1'b0);
      random_traffic(20);

      req_chan.valid <= 1'b0;
      drain_cycles = 0;
      @(negedge clock);
      while (outstanding != 0 && drain_cycles < 5000) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (24) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("** room_allocation_scheduler_core: PASSED **");
      else
         $display("** room_allocation_scheduler_core: FAILED **");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("** room_allocation_scheduler_core: FAILED **");
      $finish;
   end

endmodule
